// File: hdl/tile_midrange_binarizer_macros.svh
// assertion macros for the tile midrange binarizer
`ifndef TILE_MIDRANGE_BINARIZER_MACROS_SVH
`define TILE_MIDRANGE_BINARIZER_MACROS_SVH

// property holds in the same cycle as its condition
`define TMB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// property holds in the cycle after its condition
`define TMB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/tmb_pkg.sv
// shared constants, types and register codes of the tile midrange binarizer
package tmb_pkg;

    localparam int MAX_SIDE       = 512;
    localparam int TILES_PER_SIDE = 4;
    localparam int TILE_COUNT     = TILES_PER_SIDE * TILES_PER_SIDE;
    localparam int STORE_DEPTH    = MAX_SIDE * MAX_SIDE;

    localparam int POS_W  = $clog2(STORE_DEPTH);
    localparam int SIZE_W = POS_W + 1;
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int X_W    = $clog2(MAX_SIDE);
    localparam int TXY_W  = (TILES_PER_SIDE > 1) ? $clog2(TILES_PER_SIDE) : 1;
    localparam int TILE_W = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;
    localparam int DIV_CNT_W = $clog2(POS_W + 1);

    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;
    localparam int PIX_W     = 18;
    localparam int GRAY_W    = 8;

    // gray = (33r + 34g + 33b) / 100 via reciprocal multiply
    localparam int W_R        = 33;
    localparam int W_G        = 34;
    localparam int W_B        = 33;
    localparam int GRAY_DIV   = 100;
    localparam int GRAY_SHIFT = 21;
    localparam int GRAY_RECIP = ((1 << GRAY_SHIFT) + GRAY_DIV - 1) / GRAY_DIV;
    localparam int SUM_W      = 15;
    localparam int RECIP_W    = 15;
    localparam int PROD_W     = SUM_W + RECIP_W;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam logic [CFG_W-1:0] CFG_SIDE_RESET = CFG_W'(512);

    typedef struct packed {
        logic              action;
        logic [GRAY_W-1:0] red;
        logic [GRAY_W-1:0] green;
        logic [GRAY_W-1:0] blue;
    } t_item;

    typedef struct packed {
        logic              dark_bit;
        logic [GRAY_W-1:0] gray_level;
        logic              covered;
        logic [PIX_W-1:0]  pixel_index;
        logic              last;
    } t_result;

    typedef struct packed {
        logic [GRAY_W-1:0] max;
        logic [GRAY_W-1:0] min;
    } t_stat;

    localparam t_stat STAT_RESET = '{max: '0, min: '1};

endpackage

// File: hdl/tmb_ram.sv
// generic single-write, single-read ram with registered read data
module tmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/tmb_divmod.sv
// serial restoring divider: raster position into row and column
module tmb_divmod (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [tmb_pkg::POS_W-1:0]  i_dividend,
    input  logic [tmb_pkg::SIDE_W-1:0] i_divisor,
    output logic                     o_done,
    output logic [tmb_pkg::POS_W-1:0]  o_quotient,
    output logic [tmb_pkg::SIDE_W-1:0] o_remainder
);

    logic                            r_active;
    logic                            r_done;
    logic [tmb_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [tmb_pkg::SIDE_W-1:0]      r_rem;
    logic [tmb_pkg::POS_W-1:0]       r_quo;
    logic [tmb_pkg::SIDE_W-1:0]      r_div;
    logic [tmb_pkg::SIDE_W:0]        n_trial;
    logic                            n_fits;

    always_comb begin
        n_trial = {r_rem, r_quo[tmb_pkg::POS_W-1]};
        n_fits  = (n_trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_active <= 1'b1;
                r_cnt    <= tmb_pkg::DIV_CNT_W'(tmb_pkg::POS_W);
                r_rem    <= '0;
                r_quo    <= i_dividend;
                r_div    <= i_divisor;
            end else if (r_active) begin
                if (n_fits) begin
                    r_rem <= tmb_pkg::SIDE_W'(n_trial - {1'b0, r_div});
                end else begin
                    r_rem <= n_trial[tmb_pkg::SIDE_W-1:0];
                end
                r_quo <= {r_quo[tmb_pkg::POS_W-2:0], n_fits};
                r_cnt <= r_cnt - tmb_pkg::DIV_CNT_W'(1);
                if (r_cnt == tmb_pkg::DIV_CNT_W'(1)) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// File: hdl/tile_midrange_binarizer.sv
// top level of the tile midrange binarizer: frame store, tile statistics, control
// a read request gets its result strobe through the issue stage and the result register; loads give none
// one transaction per clock, except one busy cycle after the final load of a frame
// after reset and after every register write, busy stays high
// while the geometry is set up and the serial divider re-derives row and column
// reset clears tile statistics and positions and returns the frame size to 512 x 512
`include "tile_midrange_binarizer_macros.svh"

module tile_midrange_binarizer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  tmb_pkg::t_item                      i_item,
    output logic                                o_result_valid,
    output tmb_pkg::t_result                    o_result,
    input  logic                                i_cfg_we,
    input  logic [tmb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tmb_pkg::CFG_W-1:0]           i_cfg_data
);

    typedef enum logic [1:0] {
        S_GEOM,
        S_DIV,
        S_RUN
    } t_state;

    t_state                          r_state;
    logic [tmb_pkg::CFG_W-1:0]       r_frame_width;
    logic [tmb_pkg::CFG_W-1:0]       r_frame_height;
    logic [tmb_pkg::SIDE_W-1:0]      r_weff;
    logic [tmb_pkg::SIDE_W-1:0]      r_aw;
    logic [tmb_pkg::SIDE_W-1:0]      r_ah;
    logic [tmb_pkg::SIZE_W-1:0]      r_size;
    logic [tmb_pkg::POS_W-1:0]       r_pos;
    logic [tmb_pkg::X_W-1:0]         r_x;
    logic [tmb_pkg::POS_W-1:0]       r_y;
    logic                            r_reading;
    logic                            r_drain;
    logic [tmb_pkg::TILE_COUNT-1:0]  r_tile_vld;

    // pipeline stage after acceptance
    logic                            r_s1_vld;
    logic                            r_s1_load;
    logic [tmb_pkg::GRAY_W-1:0]      r_s1_gray;
    logic [tmb_pkg::TILE_W-1:0]      r_s1_tile;
    logic                            r_s1_cov;
    logic [tmb_pkg::POS_W-1:0]       r_s1_pos;
    logic                            r_s1_fin;
    logic                            r_s1_fwd;
    logic                            r_s1_stv;
    tmb_pkg::t_stat                  r_fwd_stat;

    logic                            r_res_vld;
    tmb_pkg::t_result                r_res;

    logic [tmb_pkg::SIDE_W-1:0]      n_weff;
    logic [tmb_pkg::SIDE_W-1:0]      n_heff;
    logic [tmb_pkg::SIZE_W-1:0]      n_size;
    logic                            n_accept;
    logic                            n_do_load;
    logic                            n_do_read;
    logic                            n_go;
    logic                            n_fin;
    logic [tmb_pkg::TXY_W-1:0]       n_tx;
    logic [tmb_pkg::TXY_W-1:0]       n_ty;
    logic [tmb_pkg::TILE_W-1:0]      n_tile;
    logic                            n_cov;
    logic [tmb_pkg::SUM_W-1:0]       n_sum;
    logic [tmb_pkg::PROD_W-1:0]      n_prod;
    logic [tmb_pkg::GRAY_W-1:0]      n_gray;
    tmb_pkg::t_stat                  n_stat_cur;
    tmb_pkg::t_stat                  n_stat_new;
    logic [tmb_pkg::GRAY_W:0]        n_mid_sum;
    logic [tmb_pkg::GRAY_W-1:0]      n_mid;
    logic                            n_frame_we;
    logic                            n_stat_we;

    logic [tmb_pkg::GRAY_W-1:0]      frame_rdata;
    tmb_pkg::t_stat                  stat_rdata;
    logic                            div_done;
    logic [tmb_pkg::POS_W-1:0]       div_quo;
    logic [tmb_pkg::SIDE_W-1:0]      div_rem;

    // geometry from the current registers
    always_comb begin
        if (int'(r_frame_width) > tmb_pkg::MAX_SIDE) begin
            n_weff = tmb_pkg::SIDE_W'(tmb_pkg::MAX_SIDE);
        end else if (r_frame_width == '0) begin
            n_weff = tmb_pkg::SIDE_W'(1);
        end else begin
            n_weff = tmb_pkg::SIDE_W'(r_frame_width);
        end
        if (int'(r_frame_height) > tmb_pkg::MAX_SIDE) begin
            n_heff = tmb_pkg::SIDE_W'(tmb_pkg::MAX_SIDE);
        end else if (r_frame_height == '0) begin
            n_heff = tmb_pkg::SIDE_W'(1);
        end else begin
            n_heff = tmb_pkg::SIDE_W'(r_frame_height);
        end
        n_size = tmb_pkg::SIZE_W'(n_weff) * tmb_pkg::SIZE_W'(n_heff);
    end

    // handshake and phase
    always_comb begin
        n_accept  = i_start && !o_busy;
        n_do_load = n_accept && (i_item.action == tmb_pkg::ACT_LOAD) && !r_reading;
        n_do_read = n_accept && (i_item.action == tmb_pkg::ACT_READ) && r_reading;
        n_go      = n_do_load || n_do_read;
        n_fin     = (({1'b0, r_pos} + tmb_pkg::SIZE_W'(1)) >= r_size);
    end

    // tile of the current position
    always_comb begin
        n_tx = '0;
        n_ty = '0;
        for (int k = 1; k < tmb_pkg::TILES_PER_SIDE; k++) begin
            if (tmb_pkg::SIDE_W'(r_x) >= tmb_pkg::SIDE_W'(k * r_aw)) begin
                n_tx = n_tx + tmb_pkg::TXY_W'(1);
            end
            if (r_y >= tmb_pkg::POS_W'(k * r_ah)) begin
                n_ty = n_ty + tmb_pkg::TXY_W'(1);
            end
        end
        n_tile = tmb_pkg::TILE_W'(int'(n_ty) * tmb_pkg::TILES_PER_SIDE + int'(n_tx));
        n_cov  = (tmb_pkg::SIDE_W'(r_x) < tmb_pkg::SIDE_W'(tmb_pkg::TILES_PER_SIDE * r_aw))
              && (r_y < tmb_pkg::POS_W'(tmb_pkg::TILES_PER_SIDE * r_ah));
    end

    // weighted gray
    always_comb begin
        n_sum  = tmb_pkg::SUM_W'(i_item.red)   * tmb_pkg::SUM_W'(tmb_pkg::W_R)
               + tmb_pkg::SUM_W'(i_item.green) * tmb_pkg::SUM_W'(tmb_pkg::W_G)
               + tmb_pkg::SUM_W'(i_item.blue)  * tmb_pkg::SUM_W'(tmb_pkg::W_B);
        n_prod = tmb_pkg::PROD_W'(n_sum) * tmb_pkg::PROD_W'(tmb_pkg::GRAY_RECIP);
        n_gray = n_prod[tmb_pkg::GRAY_SHIFT +: tmb_pkg::GRAY_W];
    end

    // tile statistics read-modify-write, forwarded from the previous write
    always_comb begin
        if (r_s1_fwd) begin
            n_stat_cur = r_fwd_stat;
        end else if (r_s1_stv) begin
            n_stat_cur = stat_rdata;
        end else begin
            n_stat_cur = tmb_pkg::STAT_RESET;
        end
        n_stat_new     = n_stat_cur;
        if (r_s1_gray < n_stat_cur.min) begin
            n_stat_new.min = r_s1_gray;
        end
        if (r_s1_gray > n_stat_cur.max) begin
            n_stat_new.max = r_s1_gray;
        end
        n_mid_sum  = {1'b0, n_stat_cur.min} + {1'b0, n_stat_cur.max};
        n_mid      = n_mid_sum[tmb_pkg::GRAY_W:1];
        n_frame_we = r_s1_vld && r_s1_load;
        n_stat_we  = r_s1_vld && r_s1_load && r_s1_cov;
    end

    tmb_ram #(
        .WIDTH (tmb_pkg::GRAY_W),
        .DEPTH (tmb_pkg::STORE_DEPTH)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (n_frame_we),
        .i_waddr (r_s1_pos),
        .i_wdata (r_s1_gray),
        .i_raddr (r_pos),
        .o_rdata (frame_rdata)
    );

    tmb_ram #(
        .WIDTH ($bits(tmb_pkg::t_stat)),
        .DEPTH (tmb_pkg::TILE_COUNT)
    ) u_stat_ram (
        .i_clk   (i_clk),
        .i_we    (n_stat_we),
        .i_waddr (r_s1_tile),
        .i_wdata (n_stat_new),
        .i_raddr (n_tile),
        .o_rdata (stat_rdata)
    );

    tmb_divmod u_divmod (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_state == S_GEOM),
        .i_dividend  (r_pos),
        .i_divisor   (n_weff),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_GEOM;
            r_frame_width  <= tmb_pkg::CFG_SIDE_RESET;
            r_frame_height <= tmb_pkg::CFG_SIDE_RESET;
            r_pos          <= '0;
            r_x            <= '0;
            r_y            <= '0;
            r_reading      <= 1'b0;
            r_drain        <= 1'b0;
            r_tile_vld     <= '0;
            r_s1_vld       <= 1'b0;
            r_res_vld      <= 1'b0;
        end else begin
            case (r_state)
                S_GEOM: begin
                    r_weff  <= n_weff;
                    r_aw    <= tmb_pkg::SIDE_W'(n_weff / tmb_pkg::TILES_PER_SIDE);
                    r_ah    <= tmb_pkg::SIDE_W'(n_heff / tmb_pkg::TILES_PER_SIDE);
                    r_size  <= n_size;
                    r_state <= i_cfg_we ? S_GEOM : S_DIV;
                end
                S_DIV: begin
                    if (i_cfg_we) begin
                        r_state <= S_GEOM;
                    end else if (div_done) begin
                        r_x     <= div_rem[tmb_pkg::X_W-1:0];
                        r_y     <= div_quo;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (i_cfg_we) begin
                        r_state <= S_GEOM;
                    end
                    if (n_go) begin
                        if (n_fin) begin
                            r_pos     <= '0;
                            r_x       <= '0;
                            r_y       <= '0;
                            r_reading <= n_do_load;
                            if (n_do_read) begin
                                r_tile_vld <= '0;
                            end
                        end else begin
                            r_pos <= r_pos + tmb_pkg::POS_W'(1);
                            if ((tmb_pkg::SIDE_W'(r_x) + tmb_pkg::SIDE_W'(1)) == r_weff) begin
                                r_x <= '0;
                                r_y <= r_y + tmb_pkg::POS_W'(1);
                            end else begin
                                r_x <= r_x + tmb_pkg::X_W'(1);
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_GEOM;
                end
            endcase

            if (i_cfg_we) begin
                case (i_cfg_index)
                    tmb_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                    tmb_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                    default: ;
                endcase
            end

            // one idle cycle after the final load
            r_drain <= n_do_load && n_fin;

            // issue stage
            r_s1_vld   <= n_go;
            r_s1_load  <= n_do_load;
            r_s1_gray  <= n_gray;
            r_s1_tile  <= n_tile;
            r_s1_cov   <= n_cov;
            r_s1_pos   <= r_pos;
            r_s1_fin   <= n_fin;
            r_s1_fwd   <= n_stat_we && (r_s1_tile == n_tile);
            r_s1_stv   <= r_tile_vld[n_tile];
            r_fwd_stat <= n_stat_new;

            // statistics write back
            if (n_stat_we) begin
                r_tile_vld[r_s1_tile] <= 1'b1;
            end

            // result register
            r_res_vld <= r_s1_vld && !r_s1_load;
            r_res.dark_bit    <= r_s1_cov && (frame_rdata < n_mid);
            r_res.gray_level  <= frame_rdata;
            r_res.covered     <= r_s1_cov;
            r_res.pixel_index <= tmb_pkg::PIX_W'(r_s1_pos);
            r_res.last        <= r_s1_fin;
        end
    end

    assign o_busy         = (r_state != S_RUN) || r_drain;
    assign o_result_valid = r_res_vld;
    assign o_result       = r_res;

    `TMB_ASSERT_NOW(a_result_from_read, o_result_valid, $past(r_s1_vld && !r_s1_load), "result without a read")
    `TMB_ASSERT_NEXT(a_drain_blocks_issue, r_drain, !r_s1_vld, "issue during drain cycle")
    `TMB_ASSERT_NOW(a_column_in_range, r_state == S_RUN, {1'b0, r_x} < r_weff, "column beyond width")

endmodule
